// ===== src/upud_pkg.sv =====
`default_nettype none

package upud_pkg;

    localparam int UNIT_W = 16;
    localparam logic [UNIT_W-1:0] PERCENT_UNIT = 16'h0025;

    typedef enum logic [1:0]
    {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_stage_t;

    // Up to two results caused by one input item. The second result, when
    // present, always carries a character and ends the string.
    typedef struct packed
    {
        logic [UNIT_W-1:0] unit0;
        logic              has0;
        logic              two;
        logic [UNIT_W-1:0] unit1;
        logic              last;
    } entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
        logic [4:0] r;
        r = 5'd0;
        if (u >= 16'h0030 && u <= 16'h0039)
        begin
            r = {1'b1, 4'(u - 16'h0030)};
        end
        else if (u >= 16'h0041 && u <= 16'h0046)
        begin
            r = {1'b1, 4'(u - 16'h0041 + 16'd10)};
        end
        else if (u >= 16'h0061 && u <= 16'h0066)
        begin
            r = {1'b1, 4'(u - 16'h0061 + 16'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/url_percent_utf8_decode.sv =====
`default_nettype none

// Decodes a stream of 16-bit code units holding percent escapes and UTF-8 byte
// sequences into 16-bit characters. The block takes one unit per clock cycle
// while its queue is not full and gives one result per clock cycle while the
// receiver is ready. Each unit yields zero, one or two results; only the final
// unit of a string with a truncated escape yields two, which the output gives
// one after the other while the input queue keeps taking units. A result passes
// through the queue and then the output register. The end of every string gives
// a result with tlast set; if no character came from the last unit, that result
// has tuser clear and data zero. All decoding state returns to reset at the end of each string.
module url_percent_utf8_decode import upud_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // code_unit[15:0]
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // out_unit[15:0]
    output logic                   m_tuser,   // has_char[0]
    output logic                   m_tlast
);

    logic      s_accept;
    logic      f_push;
    entry_t    f_entry;
    logic      q_pop;
    entry_t    q_entry;
    q_status_t q_status;

    assign s_tready = !q_status.full;
    assign s_accept = s_tvalid && s_tready;

    upud_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .code_unit     (s_tdata),
        .end_of_string (s_tlast),
        .push          (f_push),
        .push_entry    (f_entry)
    );

    upud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_entry (f_entry),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .status     (q_status)
    );

    upud_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_entry  (q_entry),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A request that ends its string is always queued.
    a_eos_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |-> f_push)
        else $error("end of string accepted without a queued result");

    a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        f_push |-> s_accept)
        else $error("result queued without an accepted request");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == 16'd0)
        else $error("result without a character is not a clean end marker");

endmodule

`default_nettype wire

// ===== src/upud_front.sv =====
`default_nettype none

module upud_front import upud_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [UNIT_W-1:0] code_unit,
    input  wire logic              end_of_string,
    output logic                   push,
    output entry_t                 push_entry
);

    esc_stage_t        stage_reg, stage_next;
    logic [UNIT_W-1:0] held_reg, held_next;
    logic [UNIT_W-1:0] acc_reg, acc_next;
    logic signed [2:0] rem_reg, rem_next;

    logic [4:0]        d1;
    logic [4:0]        d2;
    logic [7:0]        byte_val;
    logic              ch_valid;
    logic [UNIT_W-1:0] tb_acc;
    logic signed [2:0] tb_rem;
    logic [UNIT_W-1:0] cont_bits;
    logic              is_pct;

    assign is_pct = (code_unit == PERCENT_UNIT);

    // Byte assembly from the two escape digits and UTF-8 merging.
    always_comb
    begin
        d1 = hex_digit(held_reg);
        d2 = hex_digit(code_unit);
        if (!d1[4])
        begin
            byte_val = 8'd0;
        end
        else if (!d2[4])
        begin
            byte_val = {4'd0, d1[3:0]};
        end
        else
        begin
            byte_val = {d1[3:0], d2[3:0]};
        end

        ch_valid  = 1'b0;
        tb_acc    = acc_reg;
        tb_rem    = rem_reg;
        cont_bits = {10'd0, byte_val[5:0]};
        if (byte_val <= 8'h7F)
        begin
            ch_valid = 1'b1;
        end
        else if (byte_val <= 8'hBF)
        begin
            if (rem_reg == 3'sd2)
            begin
                cont_bits = {4'd0, byte_val[5:0], 6'd0};
            end
            tb_acc   = acc_reg | cont_bits;
            tb_rem   = (rem_reg <= 3'sd0) ? -3'sd1 : rem_reg - 3'sd1;
            ch_valid = (rem_reg == 3'sd1);
        end
        else if (byte_val <= 8'hDF)
        begin
            tb_acc = {5'd0, byte_val[4:0], 6'd0};
            tb_rem = 3'sd1;
        end
        else if (byte_val <= 8'hEF)
        begin
            tb_acc = {byte_val[3:0], 12'd0};
            tb_rem = 3'sd2;
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        held_next  = held_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        if (accept)
        begin
            unique case (stage_reg)
                ESC_PCT:
                begin
                    held_next  = code_unit;
                    stage_next = ESC_DIGIT;
                end
                ESC_DIGIT:
                begin
                    stage_next = ESC_NONE;
                    acc_next   = tb_acc;
                    rem_next   = tb_rem;
                end
                default:
                begin
                    stage_next = is_pct ? ESC_PCT : ESC_NONE;
                end
            endcase
            if (end_of_string)
            begin
                stage_next = ESC_NONE;
                held_next  = '0;
                acc_next   = '0;
                rem_next   = 3'sd0;
            end
        end
    end

    always_comb
    begin
        logic has_any;
        has_any    = 1'b0;
        push_entry = '0;
        unique case (stage_reg)
            ESC_PCT:
            begin
                if (end_of_string)
                begin
                    has_any          = 1'b1;
                    push_entry.unit0 = PERCENT_UNIT;
                    push_entry.has0  = 1'b1;
                    push_entry.two   = 1'b1;
                    push_entry.unit1 = code_unit;
                end
            end
            ESC_DIGIT:
            begin
                if (ch_valid)
                begin
                    has_any          = 1'b1;
                    push_entry.unit0 = ch_valid && byte_val <= 8'h7F ?
                                       {8'd0, byte_val} : tb_acc;
                    push_entry.has0  = 1'b1;
                end
            end
            default:
            begin
                if (!(is_pct && !end_of_string))
                begin
                    has_any          = 1'b1;
                    push_entry.unit0 = code_unit;
                    push_entry.has0  = 1'b1;
                end
            end
        endcase
        if (end_of_string)
        begin
            has_any         = 1'b1;
            push_entry.last = 1'b1;
        end
        push = accept && has_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ESC_NONE;
            held_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= 3'sd0;
        end
        else
        begin
            stage_reg <= stage_next;
            held_reg  <= held_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/upud_queue.sv =====
`default_nettype none

module upud_queue import upud_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      pop_entry,
    output q_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/upud_back.sv =====
`default_nettype none

module upud_back import upud_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire q_status_t          q_status,
    input  wire entry_t             q_entry,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [UNIT_W-1:0]       m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    logic              out_valid_reg, out_valid_next;
    logic [UNIT_W-1:0] out_unit_reg, out_unit_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic              sec_valid_reg, sec_valid_next;
    logic [UNIT_W-1:0] sec_unit_reg, sec_unit_next;
    logic              load_ok;

    assign load_ok = !out_valid_reg || m_tready;
    assign pop     = load_ok && !sec_valid_reg && !q_status.empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        sec_valid_next = sec_valid_reg;
        sec_unit_next  = sec_unit_reg;
        if (load_ok)
        begin
            if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_unit_next  = sec_unit_reg;
                out_has_next   = 1'b1;
                out_last_next  = 1'b1;
                sec_valid_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                out_valid_next = 1'b1;
                out_unit_next  = q_entry.unit0;
                out_has_next   = q_entry.has0;
                out_last_next  = q_entry.last && !q_entry.two;
                sec_valid_next = q_entry.two;
                sec_unit_next  = q_entry.unit1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg <= out_unit_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        sec_unit_reg <= sec_unit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== bench/url_percent_utf8_decode_test.sv =====
`default_nettype none

module url_percent_utf8_decode_test;
    timeunit 1ns;
    timeprecision 1ps;

    import upud_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_UNITS = 1000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_CAP = 40;

    typedef struct packed
    {
        logic [15:0] cu;
        logic        eos;
    } text_req_t;

    typedef struct packed
    {
        logic [15:0] ch;
        logic        has_char;
        logic        last;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    text_req_t pending_units[$];
    decoded_t  decoded_due[$];
    text_req_t next_req;
    decoded_t  want;

    esc_stage_t       esc_now = ESC_NONE;
    logic [15:0]      held_cu = 16'h0000;
    logic [15:0]      char_acc = 16'h0000;
    logic signed [2:0] cont_left = 3'sd0;

    logic unit_taken = 1'b0;
    logic hold_off = 1'b0;
    int   gap_left = 0;
    int   burst_left = 8;
    int   stall_mode = 0;
    int   stall_phase = 0;
    int   pattern_count = 0;
    logic ready_now;

    int cycle_count = 0;
    int accepted_units = 0;
    int results_seen = 0;
    int chars_seen = 0;
    int strings_seen = 0;
    int mismatches = 0;

    url_percent_utf8_decode u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int hex_val(input logic [15:0] u);
        if (u >= 16'h0030 && u <= 16'h0039)
        begin
            return int'(u - 16'h0030);
        end
        if (u >= 16'h0041 && u <= 16'h0046)
        begin
            return int'(u - 16'h0041) + 10;
        end
        if (u >= 16'h0061 && u <= 16'h0066)
        begin
            return int'(u - 16'h0061) + 10;
        end
        return -1;
    endfunction

    task automatic absorb_octet(input logic [7:0] octet, output logic got, output logic [15:0] ch);
        logic [15:0] bits6;
        got = 1'b0;
        ch = 16'h0000;
        if (octet <= 8'h7F)
        begin
            got = 1'b1;
            ch = {8'h00, octet};
        end
        else if (octet <= 8'hBF)
        begin
            bits6 = {10'd0, octet[5:0]};
            if (cont_left == 3'sd2)
            begin
                bits6 = bits6 << 6;
            end
            char_acc = char_acc | bits6;
            got = (cont_left == 3'sd1);
            ch = char_acc;
            cont_left = (cont_left <= 3'sd0) ? -3'sd1 : cont_left - 3'sd1;
        end
        else if (octet <= 8'hDF)
        begin
            char_acc = {5'd0, octet[4:0], 6'd0};
            cont_left = 3'sd1;
        end
        else if (octet <= 8'hEF)
        begin
            char_acc = {octet[3:0], 12'd0};
            cont_left = 3'sd2;
        end
    endtask

    task automatic decode_unit(input logic [15:0] cu, input logic eos);
        decoded_t    made[$];
        int          d1;
        int          d2;
        logic [7:0]  octet;
        logic        got;
        logic [15:0] ch;
        case (esc_now)
            ESC_PCT:
            begin
                if (eos)
                begin
                    made.insert(made.size(), decoded_t'{PERCENT_UNIT, 1'b1, 1'b0});
                    made.insert(made.size(), decoded_t'{cu, 1'b1, 1'b0});
                    esc_now = ESC_NONE;
                end
                else
                begin
                    held_cu = cu;
                    esc_now = ESC_DIGIT;
                end
            end
            ESC_DIGIT:
            begin
                d1 = hex_val(held_cu);
                d2 = hex_val(cu);
                if (d1 < 0)
                begin
                    octet = 8'h00;
                end
                else if (d2 < 0)
                begin
                    octet = 8'(d1);
                end
                else
                begin
                    octet = 8'(d1 * 16 + d2);
                end
                esc_now = ESC_NONE;
                absorb_octet(octet, got, ch);
                if (got)
                begin
                    made.insert(made.size(), decoded_t'{ch, 1'b1, 1'b0});
                end
            end
            default:
            begin
                esc_now = ESC_NONE;
                if (cu == PERCENT_UNIT && !eos)
                begin
                    esc_now = ESC_PCT;
                end
                else
                begin
                    made.insert(made.size(), decoded_t'{cu, 1'b1, 1'b0});
                end
            end
        endcase
        if (eos)
        begin
            if (made.size() == 0)
            begin
                made.insert(made.size(), decoded_t'{16'h0000, 1'b0, 1'b0});
            end
            made[made.size() - 1].last = 1'b1;
            esc_now = ESC_NONE;
            held_cu = 16'h0000;
            char_acc = 16'h0000;
            cont_left = 3'sd0;
        end
        foreach (made[i])
        begin
            decoded_due.insert(decoded_due.size(), made[i]);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatches < REPORT_CAP)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatches++;
    endtask

    task automatic put_unit(input logic [15:0] cu, input logic eos);
        pending_units.insert(pending_units.size(), text_req_t'{cu, eos});
    endtask

    task automatic put_text(input string s, input logic eos_last);
        for (int i = 0; i < s.len(); i++)
        begin
            put_unit({8'h00, s[i]}, eos_last && (i == s.len() - 1));
        end
    endtask

    function automatic logic [15:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 16'h0030 + n;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return 16'h0041 + n - 16'd10;
        end
        return 16'h0061 + n - 16'd10;
    endfunction

    function automatic logic [15:0] odd_digit();
        if ($urandom_range(0, 1) == 1)
        begin
            return hex_char(4'($urandom_range(0, 15)));
        end
        return 16'($urandom);
    endfunction

    task automatic put_escape(input logic [7:0] octet);
        put_unit(PERCENT_UNIT, 1'b0);
        put_unit(hex_char(octet[7:4]), 1'b0);
        put_unit(hex_char(octet[3:0]), 1'b0);
    endtask

    task automatic build_random_string();
        int          tokens;
        int          kind;
        logic [15:0] cp;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(0, 15);
            if (kind < 3)
            begin
                put_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
            end
            else if (kind < 5)
            begin
                put_unit(16'($urandom), 1'b0);
            end
            else if (kind < 7)
            begin
                put_escape(8'($urandom_range(0, 8'h7F)));
            end
            else if (kind < 9)
            begin
                cp = 16'($urandom_range(16'h0080, 16'h07FF));
                put_escape({3'b110, cp[10:6]});
                put_escape({2'b10, cp[5:0]});
            end
            else if (kind < 11)
            begin
                cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                put_escape({4'b1110, cp[15:12]});
                put_escape({2'b10, cp[11:6]});
                put_escape({2'b10, cp[5:0]});
            end
            else if (kind < 13)
            begin
                put_escape(8'($urandom));
            end
            else if (kind < 14)
            begin
                put_unit(PERCENT_UNIT, 1'b0);
                put_unit(odd_digit(), 1'b0);
                put_unit(odd_digit(), 1'b0);
            end
            else
            begin
                cp = 16'($urandom);
                put_escape({4'b1110, cp[15:12]});
                if ($urandom_range(0, 1) == 1)
                begin
                    put_escape({2'b10, cp[11:6]});
                end
                put_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
            end
        end
        case ($urandom_range(0, 7))
            0:
            begin
                put_unit(PERCENT_UNIT, 1'b1);
            end
            1:
            begin
                put_unit(PERCENT_UNIT, 1'b0);
                put_unit(16'($urandom), 1'b1);
            end
            default:
            begin
                pending_units[pending_units.size() - 1].eos = 1'b1;
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || unit_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_units.size() > 0)
            begin
                next_req = pending_units.pop_front();
                s_tdata <= next_req.cu;
                s_tlast <= next_req.eos;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 24);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        unit_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 80);
        end
        else
        begin
            stall_phase--;
        end
        pattern_count++;
        case (stall_mode)
            0: ready_now = 1'b1;
            1: ready_now = ($urandom_range(0, 1) == 1);
            2: ready_now = (pattern_count % 3 == 0);
            default: ready_now = ($urandom_range(0, 3) == 0);
        endcase
        m_tready <= rst_n && !hold_off && ready_now;
    end

    // A request is predicted at the edge that accepts it, before any result of
    // the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_unit(s_tdata, s_tlast);
                accepted_units++;
                unit_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (decoded_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result data %h user %b last %b",
                                            m_tdata, m_tuser, m_tlast));
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        flag_mismatch($sformatf("result %0d out_unit %h, want %h",
                                                results_seen, m_tdata, want.ch));
                    end
                    if (m_tuser !== want.has_char)
                    begin
                        flag_mismatch($sformatf("result %0d has_char %b, want %b",
                                                results_seen, m_tuser, want.has_char));
                    end
                    if (m_tlast !== want.last)
                    begin
                        flag_mismatch($sformatf("result %0d last_of_string %b, want %b",
                                                results_seen, m_tlast, want.last));
                    end
                end
                results_seen++;
                if (m_tuser)
                begin
                    chars_seen++;
                end
                if (m_tlast)
                begin
                    strings_seen++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results still due", decoded_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver stops for a long stretch while the sender keeps offering,
    // so the block fills up and must stall its input.
    initial
    begin
        wait (accepted_units >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        put_unit(16'h0000, 1'b0);
        put_unit(16'hFFFF, 1'b1);
        put_text("%az", 1'b0);
        put_text("%E2%82%AC", 1'b1);
        put_text("%80", 1'b1);
        put_text("%FF", 1'b0);
        put_text("%%3", 1'b0);
        put_text("%", 1'b1);
        put_text("%x", 1'b1);
        while (pending_units.size() < RANDOM_UNITS + 26)
        begin
            build_random_string();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_units.size() != 0 || s_tvalid || decoded_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d code units in %0d strings, with bursts, gaps and stalls.",
                 accepted_units, strings_seen);
        $display("Checked %0d results (%0d characters), %0d mismatches.",
                 results_seen, chars_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/upud_pkg.sv
src/upud_front.sv
src/upud_queue.sv
src/upud_back.sv
src/url_percent_utf8_decode.sv
bench/url_percent_utf8_decode_test.sv
